@@ rtl/wvm_pkg.sv @@
// ============================================================================
// wvm_pkg
// Shared constants, types and helper functions of the wavetable voice mixer.
// ============================================================================
package wvm_pkg;

   localparam int TableSize    = 1024;
   localparam int VoiceCount   = 4;
   localparam int OscsPerVoice = 3;
   localparam int OscTotal     = VoiceCount * OscsPerVoice;
   localparam int IdxBits      = $clog2(TableSize);
   localparam int VoiceBits    = 2;
   localparam int OscBits      = $clog2(OscTotal);
   localparam int OscSubBits   = 2;

   localparam logic [31:0] BaseStep   = 32'd10713070;
   localparam logic [31:0] DetuneStep = 32'd10713;
   localparam logic [23:0] CountMax   = 24'hFFFFFF;
   localparam logic [24:0] EnvFull    = 25'd16777216;
   localparam logic [15:0] ThirdQ16   = 16'd21845;

   localparam logic [2:0] RegLevelSaw  = 3'd0;
   localparam logic [2:0] RegLevelTri  = 3'd1;
   localparam logic [2:0] RegLevelSq   = 3'd2;
   localparam logic [2:0] RegLevelPu   = 3'd3;
   localparam logic [2:0] RegAttackLen = 3'd4;
   localparam logic [2:0] RegAttackStp = 3'd5;
   localparam logic [2:0] RegDecayLen  = 3'd6;
   localparam logic [2:0] RegDecayStp  = 3'd7;

   localparam logic CmdTick = 1'b0;
   localparam logic CmdNote = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 note_write;
      logic                 env_step;
      logic                 osc_step;
      logic                 voice_close;
      logic                 total_clear;
      logic [VoiceBits-1:0] voice;
      logic [OscBits-1:0]   osc;
   } cmd_type;

   typedef struct packed {
      logic [15:0] level_saw;
      logic [15:0] level_tri;
      logic [15:0] level_sq;
      logic [15:0] level_pu;
      logic [15:0] attack_len;
      logic [24:0] attack_step;
      logic [15:0] decay_len;
      logic [24:0] decay_step;
   } cfg_type;

   function automatic logic [31:0] octave9_step(input logic [3:0] r);
      logic [31:0] v;
      case (r)
         4'd0:    v = 32'd815363807;
         4'd1:    v = 32'd863847862;
         4'd2:    v = 32'd915214929;
         4'd3:    v = 32'd969636441;
         4'd4:    v = 32'd1027294024;
         4'd5:    v = 32'd1088380105;
         4'd6:    v = 32'd1153098554;
         4'd7:    v = 32'd1221665362;
         4'd8:    v = 32'd1294309365;
         4'd9:    v = 32'd1371273005;
         4'd10:   v = 32'd1452813141;
         4'd11:   v = 32'd1539201906;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   // Phase step of a MIDI note, rounded half up after the octave shift.
   function automatic logic [31:0] note_step(input logic [6:0] n);
      logic [12:0] q;
      logic [3:0]  k;
      logic [6:0]  r;
      logic [3:0]  sh;
      logic [32:0] v;
      // The octave is n * 43 / 512, which equals n / 12 for every note number.
      q  = 13'(n) * 13'd43;
      k  = q[12:9];
      r  = n - ({3'b0, k} << 3) - ({3'b0, k} << 2);
      sh = 4'd10 - k;
      v  = {1'b0, octave9_step(r[3:0])};
      if (sh != 4'd0) begin
         v = v + (33'd1 << (sh - 4'd1));
      end
      v = v >> sh;
      return v[31:0];
   endfunction

endpackage

@@ rtl/wavetable_voice_mixer_unit.sv @@
// A tick walks each voice in turn through an envelope step, one step per oscillator,
// a sum step and a close step, then loads the sample and raises rsp_tvalid. A new
// beat is taken only in idle and while no result waits for rsp_tready.
// A note beat gives no result.
// Reset is synchronous, active high; it restores the register defaults and voice state.
// ============================================================================
// wavetable_voice_mixer_unit
// Top level: configuration registers, controller and datapath.
// ============================================================================
module wavetable_voice_mixer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // voice[1:0], duration_samples[25:2], note[32:26]
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // sample[23:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [24:0] csr_data
);

   wvm_pkg::cfg_type cfg_ff;
   wvm_pkg::cmd_type cmd;
   logic             out_load;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_saw   <= 16'd0;
         cfg_ff.level_tri   <= 16'd32768;
         cfg_ff.level_sq    <= 16'd13107;
         cfg_ff.level_pu    <= 16'd0;
         cfg_ff.attack_len  <= 16'd441;
         cfg_ff.attack_step <= 25'd38043;
         cfg_ff.decay_len   <= 16'd4410;
         cfg_ff.decay_step  <= 25'd3804;
      end else if (csr_valid) begin
         unique case (csr_index)
            wvm_pkg::RegLevelSaw:  cfg_ff.level_saw   <= csr_data[15:0];
            wvm_pkg::RegLevelTri:  cfg_ff.level_tri   <= csr_data[15:0];
            wvm_pkg::RegLevelSq:   cfg_ff.level_sq    <= csr_data[15:0];
            wvm_pkg::RegLevelPu:   cfg_ff.level_pu    <= csr_data[15:0];
            wvm_pkg::RegAttackLen: cfg_ff.attack_len  <= csr_data[15:0];
            wvm_pkg::RegAttackStp: cfg_ff.attack_step <= csr_data;
            wvm_pkg::RegDecayLen:  cfg_ff.decay_len   <= csr_data[15:0];
            wvm_pkg::RegDecayStp:  cfg_ff.decay_step  <= csr_data;
            default: ;
         endcase
      end
   end

   wvm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .req_voice  (req_tdata[1:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_load   (out_load),
      .cmd        (cmd)
   );

   wvm_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .cfg          (cfg_ff),
      .req_duration (req_tdata[25:2]),
      .req_note     (req_tdata[32:26]),
      .out_load     (out_load),
      .rsp_sample   (rsp_tdata)
   );

endmodule

@@ rtl/wvm_ctrl.sv @@
// ============================================================================
// wvm_ctrl
// Sequencer: walks the voices of a tick in turn, and each voice's oscillators one per cycle.
// ============================================================================
module wvm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_cmd,
   input  logic [1:0]          req_voice,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic                out_load,
   output wvm_pkg::cmd_type    cmd
);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StEnv   = 3'd1;
   localparam logic [2:0] StOsc   = 3'd2;
   localparam logic [2:0] StSum   = 3'd3;
   localparam logic [2:0] StFinal = 3'd4;
   localparam logic [2:0] StOut   = 3'd5;

   logic [2:0]                     state_ff, state_in;
   logic [wvm_pkg::VoiceBits-1:0]  voice_ff, voice_in;
   logic [wvm_pkg::OscSubBits-1:0] sub_ff, sub_in;
   logic                           valid_ff, valid_in;
   logic                           accept;
   logic                           last_voice;
   logic                           last_osc;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == StIdle) && (!valid_ff || rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign last_voice = voice_ff == wvm_pkg::VoiceBits'(wvm_pkg::VoiceCount - 1);
   assign last_osc   = sub_ff == wvm_pkg::OscSubBits'(wvm_pkg::OscsPerVoice - 1);

   always_comb begin
      state_in = state_ff;
      voice_in = voice_ff;
      sub_in   = sub_ff;
      valid_in = valid_ff;
      out_load = 1'b0;
      cmd      = '0;
      cmd.voice = accept ? req_voice : voice_ff;
      cmd.osc  = wvm_pkg::OscBits'(voice_ff * wvm_pkg::OscBits'(wvm_pkg::OscsPerVoice))
                 + wvm_pkg::OscBits'(sub_ff);
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               if (req_cmd == wvm_pkg::CmdNote) begin
                  cmd.note_write = 1'b1;
               end else begin
                  cmd.total_clear = 1'b1;
                  voice_in = '0;
                  sub_in   = '0;
                  state_in = StEnv;
               end
            end
         end
         StEnv: begin
            cmd.env_step = 1'b1;
            state_in = StOsc;
         end
         StOsc: begin
            cmd.osc_step = 1'b1;
            if (last_osc) begin
               state_in = StSum;
            end else begin
               sub_in = sub_ff + 1'b1;
            end
         end
         StSum: begin
            // The last oscillator's mix is added to the voice sum here.
            state_in = StFinal;
         end
         StFinal: begin
            cmd.voice_close = 1'b1;
            sub_in = '0;
            if (last_voice) begin
               state_in = StOut;
            end else begin
               voice_in = voice_ff + 1'b1;
               state_in = StEnv;
            end
         end
         StOut: begin
            out_load = 1'b1;
            valid_in = 1'b1;
            state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         voice_ff <= '0;
         sub_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         voice_ff <= voice_in;
         sub_ff   <= sub_in;
         valid_ff <= valid_in;
      end
   end

endmodule

@@ rtl/wvm_datapath.sv @@
// ============================================================================
// wvm_datapath
// Oscillator, envelope and mixing arithmetic plus the per-voice state.
// ============================================================================
module wvm_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  wvm_pkg::cmd_type     cmd,
   input  wvm_pkg::cfg_type     cfg,
   input  logic [23:0]          req_duration,
   input  logic [6:0]           req_note,
   input  logic                 out_load,
   output logic [23:0]          rsp_sample
);

   localparam int N = wvm_pkg::TableSize;
   localparam int H = N / 2;
   localparam int P = N / 10;
   localparam int Ib = wvm_pkg::IdxBits;

   logic [31:0] phase_ff [wvm_pkg::OscTotal];
   logic [31:0] step_ff  [wvm_pkg::OscTotal];
   logic [24:0] env_ff   [wvm_pkg::VoiceCount];
   logic [23:0] count_ff [wvm_pkg::VoiceCount];
   logic signed [24:0] dbeg_ff [wvm_pkg::VoiceCount];
   logic [wvm_pkg::VoiceCount-1:0] armed_ff;

   logic [24:0]        cur_env_ff;
   logic signed [40:0] vsum_ff;
   logic signed [38:0] mix_ff;
   logic               mix_vld_ff;
   logic signed [27:0] total_ff;
   logic [23:0]        sample_ff;

   // Oscillator advance.
   logic [32:0]         psum;
   logic [31:0]         pnew;
   logic [Ib-1:0]       idx;
   logic signed [21:0]  saw, tri_v, sq, pu;
   logic [Ib:0]         jdx;
   logic signed [38:0]  mix_in;

   assign psum = {1'b0, phase_ff[cmd.osc]} + {1'b0, step_ff[cmd.osc]};
   assign pnew = psum[32] ? 32'd0 : psum[31:0];
   assign idx  = pnew[31 -: Ib];
   assign jdx  = {1'b0, idx} - (Ib+1)'(H);

   // The half table is a power of two, so the triangle slopes are shifts.
   always_comb begin
      saw = 22'($signed({1'b0, idx, 21'd0} >> Ib)) - 22'sd1048576;
      if (idx < Ib'(H)) begin
         tri_v = 22'($signed({2'b0, idx, 21'd0} >> (Ib - 1))) - 22'sd1048576;
      end else if (jdx < (Ib+1)'(H)) begin
         tri_v = 22'sd1048576 - 22'($signed({1'b0, jdx, 21'd0} >> (Ib - 1)));
      end else begin
         tri_v = -22'sd1048576;
      end
      sq = (idx < Ib'(H)) ? -22'sd1048576 : 22'sd1048576;
      pu = (idx < Ib'(P)) ? -22'sd1048576 : 22'sd1048576;
      mix_in = 39'(saw * $signed({1'b0, cfg.level_saw}))
             + 39'(tri_v * $signed({1'b0, cfg.level_tri}))
             + 39'(sq * $signed({1'b0, cfg.level_sq}))
             + 39'(pu * $signed({1'b0, cfg.level_pu}));
   end

   // Envelope step of the current voice.
   logic [24:0] lv;
   logic [26:0] lv_t;
   logic        in_attack, in_decay;
   always_comb begin
      lv        = env_ff[cmd.voice];
      in_attack = count_ff[cmd.voice] < cfg.attack_len;
      in_decay  = $signed({1'b0, count_ff[cmd.voice]}) > dbeg_ff[cmd.voice];
      lv_t      = {2'b0, lv};
      if (in_attack) begin
         lv_t = lv_t + {2'b0, cfg.attack_step};
      end else if (in_decay) begin
         lv_t = lv_t - {2'b0, cfg.decay_step};
      end
      if ($signed(lv_t) < 0) begin
         lv = '0;
      end else if (lv_t > {2'b0, wvm_pkg::EnvFull}) begin
         lv = wvm_pkg::EnvFull;
      end else begin
         lv = lv_t[24:0];
      end
   end

   // Voice close: the one-third scale and the envelope scale sit in separate
   // register stages.
   logic signed [56:0] t_prod;
   logic signed [24:0] t_val;
   logic signed [24:0] t_ff;
   logic               t_vld_ff;
   logic signed [50:0] e_prod;
   logic signed [26:0] contrib;
   logic [24:0]        t_env_ff;

   assign t_prod  = vsum_ff * $signed({1'b0, wvm_pkg::ThirdQ16});
   assign t_val   = 25'(t_prod >>> 32);
   assign e_prod  = t_ff * $signed({1'b0, t_env_ff});
   assign contrib = 27'(e_prod >>> 26);

   logic signed [27:0] tot_next;
   assign tot_next = total_ff + 28'(contrib);

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff   <= '0;
         mix_vld_ff <= 1'b0;
         t_vld_ff   <= 1'b0;
         for (int k = 0; k < wvm_pkg::OscTotal; k++) begin
            phase_ff[k] <= '0;
            step_ff[k]  <= wvm_pkg::BaseStep
                           + 32'(k % wvm_pkg::OscsPerVoice) * wvm_pkg::DetuneStep;
         end
         for (int v = 0; v < wvm_pkg::VoiceCount; v++) begin
            env_ff[v]   <= '0;
            count_ff[v] <= '0;
            dbeg_ff[v]  <= '0;
         end
      end else begin
         mix_vld_ff <= cmd.osc_step;
         t_vld_ff   <= cmd.voice_close;
         if (cmd.note_write) begin
            for (int o = 0; o < wvm_pkg::OscsPerVoice; o++) begin
               step_ff[wvm_pkg::OscBits'(cmd.voice * wvm_pkg::OscsPerVoice + o)]
                  <= wvm_pkg::note_step(req_note);
            end
            dbeg_ff[cmd.voice]  <= $signed({1'b0, req_duration})
                                   - $signed({9'd0, cfg.decay_len});
            env_ff[cmd.voice]   <= '0;
            count_ff[cmd.voice] <= '0;
            armed_ff[cmd.voice] <= 1'b1;
         end
         if (cmd.env_step && armed_ff[cmd.voice]) begin
            env_ff[cmd.voice] <= lv;
            if (count_ff[cmd.voice] != wvm_pkg::CountMax) begin
               count_ff[cmd.voice] <= count_ff[cmd.voice] + 1'b1;
            end
         end
         if (cmd.osc_step) begin
            phase_ff[cmd.osc] <= pnew;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.env_step) begin
         cur_env_ff <= armed_ff[cmd.voice] ? lv : 25'd0;
         vsum_ff    <= '0;
      end else if (mix_vld_ff) begin
         vsum_ff <= vsum_ff + 41'(mix_ff);
      end
      mix_ff <= mix_in;
      if (cmd.voice_close) begin
         t_ff     <= t_val;
         t_env_ff <= cur_env_ff;
      end
      if (cmd.total_clear) begin
         total_ff <= '0;
      end else if (t_vld_ff) begin
         total_ff <= tot_next;
      end
      if (out_load) begin
         if (tot_next > 28'sd8388607) begin
            sample_ff <= 24'h7FFFFF;
         end else if (tot_next < -28'sd8388608) begin
            sample_ff <= 24'h800000;
         end else begin
            sample_ff <= tot_next[23:0];
         end
      end
   end

   assign rsp_sample = sample_ff;

endmodule

@@ rtl/wvm_checker.sv @@
// ============================================================================
// wvm_checker
// Port-level checks of the mixer's handshakes.
// ============================================================================
module wvm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed while stalled");

   a_note_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser && !rsp_tvalid |=> !rsp_tvalid)
      else $error("note beat produced a result");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser |=> !req_tready)
      else $error("new beat accepted while a tick is in progress");

   a_tick_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared too early after a tick");

endmodule

bind wavetable_voice_mixer_unit wvm_checker u_wvm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ dv/wavetable_voice_mixer_unit_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// wavetable_voice_mixer_unit_tb
// Drives random notes and ticks through the voice mixer, predicts every
// sample from its own model of phases, envelopes and the waveform mix, and
// checks each result beat in order, over several register settings.
// ============================================================================
module wavetable_voice_mixer_unit_tb;

   localparam int NumVoices = wvm_pkg::VoiceCount;
   localparam int NumOscs   = wvm_pkg::OscTotal;

   // Predicts samples from a private copy of the mixer state.
   class sample_board;
      logic [15:0] lvl_saw, lvl_tri, lvl_sq, lvl_pu, att_len, dec_len;
      logic [24:0] att_step, dec_step;
      logic [31:0] phase [NumOscs];
      logic [31:0] step [NumOscs];
      longint      env [NumVoices];
      logic [23:0] count [NumVoices];
      longint      dec_begin [NumVoices];
      bit          armed [NumVoices];
      logic [23:0] pending [$];
      int          errors;

      function void clear();
         lvl_saw = 0; lvl_tri = 32768; lvl_sq = 13107; lvl_pu = 0;
         att_len = 441; att_step = 38043; dec_len = 4410; dec_step = 3804;
         for (int k = 0; k < NumOscs; k++) begin
            phase[k] = 0;
            step[k]  = wvm_pkg::BaseStep + (k % 3) * wvm_pkg::DetuneStep;
         end
         for (int v = 0; v < NumVoices; v++) begin
            env[v] = 0; count[v] = 0; dec_begin[v] = 0; armed[v] = 0;
         end
         pending.delete();
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [24:0] d);
         case (idx)
            wvm_pkg::RegLevelSaw:  lvl_saw = d[15:0];
            wvm_pkg::RegLevelTri:  lvl_tri = d[15:0];
            wvm_pkg::RegLevelSq:   lvl_sq = d[15:0];
            wvm_pkg::RegLevelPu:   lvl_pu = d[15:0];
            wvm_pkg::RegAttackLen: att_len = d[15:0];
            wvm_pkg::RegAttackStp: att_step = d;
            wvm_pkg::RegDecayLen:  dec_len = d[15:0];
            wvm_pkg::RegDecayStp:  dec_step = d;
            default: ;
         endcase
      endfunction

      // Floor shift of a signed value (arithmetic shift rounds down).
      function longint fshift(longint x, int s);
         return x >>> s;
      endfunction

      function longint pitch(logic [6:0] n);
         longint unsigned v;
         int sh;
         sh = 10 - n / 12;
         v  = octave_entry(n % 12);
         if (sh > 0) v += 64'd1 << (sh - 1);
         return longint'(v >> sh);
      endfunction

      function longint unsigned octave_entry(int r);
         longint unsigned t [12] = '{815363807, 863847862, 915214929, 969636441,
            1027294024, 1088380105, 1153098554, 1221665362, 1294309365,
            1371273005, 1452813141, 1539201906};
         return t[r];
      endfunction

      function longint mix_at(longint i);
         longint one, saw, tri_v, sq, pu;
         one = 1048576;
         saw = (2 * i * one) / 1024 - one;
         if (i < 512) tri_v = (2 * i * one) / 512 - one;
         else tri_v = one - (2 * (i - 512) * one) / 512;
         sq = (i < 512) ? -one : one;
         pu = (i < 102) ? -one : one;
         return saw * lvl_saw + tri_v * lvl_tri + sq * lvl_sq + pu * lvl_pu;
      endfunction

      function void note_input(logic cmd, logic [39:0] d);
         logic [1:0] v;
         longint st, total, lv, vsum, t, e;
         longint unsigned s;
         int k;
         v = d[1:0];
         if (cmd == wvm_pkg::CmdNote) begin
            st = pitch(d[32:26]);
            for (int o = 0; o < 3; o++) step[v * 3 + o] = st[31:0];
            dec_begin[v] = longint'(d[25:2]) - longint'(dec_len);
            env[v] = 0; count[v] = 0; armed[v] = 1;
            return;
         end
         total = 0;
         for (int vv = 0; vv < NumVoices; vv++) begin
            lv = 0;
            if (armed[vv]) begin
               lv = env[vv];
               if (count[vv] < att_len) lv += att_step;
               else if (longint'(count[vv]) > dec_begin[vv]) lv -= dec_step;
               if (lv > 16777216) lv = 16777216;
               if (lv < 0) lv = 0;
               env[vv] = lv;
               if (count[vv] != wvm_pkg::CountMax) count[vv]++;
            end
            vsum = 0;
            for (int o = 0; o < 3; o++) begin
               k = vv * 3 + o;
               s = longint'(phase[k]) + longint'(step[k]);
               phase[k] = (s >= 64'h1_0000_0000) ? 32'd0 : s[31:0];
               vsum += mix_at(longint'(phase[k][31:22]));
            end
            t = fshift(vsum * 21845, 32);
            e = fshift(t * lv, 24);
            total += fshift(e, 2);
         end
         if (total > 8388607) total = 8388607;
         if (total < -8388608) total = -8388608;
         pending.push_back(total[23:0]);
      endfunction

      function void check_sample(logic [23:0] got);
         logic [23:0] want;
         if (pending.size() == 0) begin
            $error("sample: unexpected beat, actual %0d", $signed(got));
            errors++;
            return;
         end
         want = pending.pop_front();
         if (want !== got) begin
            $error("sample: expected %0d, actual %0d", $signed(want), $signed(got));
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [24:0] csr_data = '0;

   sample_board board = new();
   bit          calm;   // no idling on either side while set

   always #5 clock = ~clock;

   wavetable_voice_mixer_unit dut (.*);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_sample(rsp_tdata);
   end

   always @(negedge clock) begin
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 33);
   end

   // The valid line stays high between back-to-back beats and drops only
   // while idling or draining.
   task automatic send_item(logic cmd, logic [1:0] v, logic [23:0] dur, logic [6:0] n);
      while (!calm && $urandom_range(99) < 33) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= cmd;
      req_tdata  <= {7'd0, n, dur, v};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_input(cmd, {7'd0, n, dur, v});
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [24:0] d);
      csr_valid <= 1; csr_index <= idx; csr_data <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, d);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   task automatic random_item();
      int r;
      logic [23:0] dur;
      r = $urandom_range(99);
      dur = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(3000));
      if (r < 20) send_item(wvm_pkg::CmdNote, 2'($urandom), dur, 7'($urandom));
      else send_item(wvm_pkg::CmdTick, 2'($urandom), 24'($urandom), 7'($urandom));
   endtask

   initial begin
      board.clear();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // Directed: extreme notes and durations, every voice, then ticks.
      send_item(wvm_pkg::CmdTick, 2'd0, 24'd0, 7'd0);
      send_item(wvm_pkg::CmdNote, 2'd0, 24'd0, 7'd0);
      send_item(wvm_pkg::CmdNote, 2'd1, 24'hFFFFFF, 7'd127);
      send_item(wvm_pkg::CmdNote, 2'd2, 24'd500, 7'd69);
      send_item(wvm_pkg::CmdNote, 2'd3, 24'd1, 7'd120);
      repeat (12) send_item(wvm_pkg::CmdTick, 2'd3, 24'hFFFFFF, 7'd127);
      drain();
      // Settings: extremes, huge steps for clamping, zero lengths.
      write_csr(wvm_pkg::RegLevelSaw, 25'hFFFF);
      write_csr(wvm_pkg::RegLevelTri, 25'hFFFF);
      write_csr(wvm_pkg::RegLevelSq, 25'hFFFF);
      write_csr(wvm_pkg::RegLevelPu, 25'hFFFF);
      write_csr(wvm_pkg::RegAttackLen, 25'd0);
      write_csr(wvm_pkg::RegAttackStp, 25'd16777216);
      write_csr(wvm_pkg::RegDecayLen, 25'd0);
      write_csr(wvm_pkg::RegDecayStp, 25'd16777216);
      send_item(wvm_pkg::CmdNote, 2'd0, 24'd2, 7'd60);
      send_item(wvm_pkg::CmdNote, 2'd1, 24'd0, 7'd127);
      repeat (6) send_item(wvm_pkg::CmdTick, 2'd0, 24'd0, 7'd0);
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         write_csr(wvm_pkg::RegLevelSaw, 25'($urandom));
         write_csr(wvm_pkg::RegLevelTri, 25'($urandom));
         write_csr(wvm_pkg::RegLevelSq, 25'($urandom));
         write_csr(wvm_pkg::RegLevelPu, ph == 5 ? 25'd0 : 25'($urandom));
         write_csr(wvm_pkg::RegAttackLen, 25'($urandom_range(1, ph < 3 ? 60 : 65535)));
         write_csr(wvm_pkg::RegAttackStp, 25'($urandom_range(0, 16777216)));
         write_csr(wvm_pkg::RegDecayLen, 25'($urandom_range(1, ph < 3 ? 60 : 65535)));
         write_csr(wvm_pkg::RegDecayStp,
                   25'($urandom_range(0, ph == 4 ? 16777216 : 400000)));
         calm = (ph == 2);
         repeat (300) random_item();
      end
      calm = 0;
      drain();
      if (board.errors == 0 && board.pending.size() == 0) $display("== PASS ==");
      else begin
         if (board.pending.size() != 0)
            $error("sample: %0d expected beats never arrived", board.pending.size());
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("== FAIL ==");
      $finish;
   end
endmodule
